// File: src/pgq_pkg.sv
// ----------------------------------------------------------------------------
// pgq_pkg
// Shared types and constants of the pinch gesture qualifier: beat layouts,
// result codes, register map and the plan handed from front to back.
// ----------------------------------------------------------------------------
package pgq_pkg;

    localparam int NUM_HANDS_DEF = 2;
    localparam int SLOT_COUNT    = 6;
    localparam int QUEUE_DEPTH   = 2;
    localparam int TIME_W        = 63;
    localparam int STR_W         = 11;
    localparam int PT_W          = 16;
    localparam int WIN_W         = 32;
    localparam int SWIPE_W       = 4;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    localparam logic signed [PT_W-1:0] OFF_PLANE = 16'sd8192;

    localparam logic [STR_W-1:0] PRESS_TH_RST   = 11'd922;
    localparam logic [STR_W-1:0] RELEASE_TH_RST = 11'd614;
    localparam logic [STR_W-1:0] FREEZE_TH_RST  = 11'd512;
    localparam logic [WIN_W-1:0] DOUBLE_WIN_RST = 32'd300000000;
    localparam logic [WIN_W-1:0] LOCKOUT_RST    = 32'd2000000000;
    localparam logic [1:0]       HANDS_RST      = 2'b11;

    typedef enum logic [2:0] {
        KIND_MOVE,
        KIND_DOWN,
        KIND_UP,
        KIND_DOUBLE,
        KIND_SWIPE_L,
        KIND_SWIPE_R,
        KIND_SWIPE_U,
        KIND_SWIPE_D
    } kind_t;

    typedef enum logic [2:0] {
        REG_PRESS_TH,
        REG_RELEASE_TH,
        REG_FREEZE_TH,
        REG_DOUBLE_WIN,
        REG_LOCKOUT_WIN,
        REG_AIM_SUP,
        REG_SWIPE_SUP,
        REG_HANDS
    } reg_idx_t;

    typedef struct packed {
        logic                     hand;
        logic [TIME_W-1:0]        now_time;
        logic [TIME_W-1:0]        controller_time;
        logic                     tracked;
        logic [2:0]               aim_status;
        logic [STR_W-1:0]         pinch_strength;
        logic signed [PT_W-1:0]   point_x;
        logic signed [PT_W-1:0]   point_y;
        logic [SWIPE_W-1:0]       swipe_flags;
    } sample_t;

    typedef struct packed {
        logic [2:0]               event_kind;
        logic                     event_hand;
        logic [STR_W-1:0]         event_value;
        logic signed [PT_W-1:0]   pointer_x;
        logic signed [PT_W-1:0]   pointer_y;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic [STR_W-1:0] press_threshold;
        logic [STR_W-1:0] release_threshold;
        logic [STR_W-1:0] freeze_threshold;
        logic [WIN_W-1:0] double_window;
        logic [WIN_W-1:0] lockout_window;
        logic             aim_supported;
        logic             swipes_supported;
        logic [1:0]       hands_present;
    } cfg_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   hand;
        logic [STR_W-1:0]       value;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } evt_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        evt_t [SLOT_COUNT-1:0] slot;
    } plan_t;

endpackage

// File: src/pinch_gesture_qualifier.sv
// ----------------------------------------------------------------------------
// pinch_gesture_qualifier
// Per-hand pinch sample qualifier: controller lockout, tracking loss,
// pointer freeze, press/release hysteresis, double pinch and swipe edges.
// ----------------------------------------------------------------------------
//  channel   signals                        beat
//  smp       smp_valid / smp_stall          one hand sample (sample_t)
//  evt       evt_valid / evt_stall          one result (result_t)
//  apb       psel penable pwrite paddr ...  one register write or read
//
//  A sample is classified in the cycle it is accepted; a sample may follow
//  every cycle while the two-entry plan queue has room.
//  Results leave one per cycle from the output register while evt_stall is
//  low; a sample with no results is not queued and produces no beat.
//  smp_stall is high only while the plan queue is full.
//  Reset clears the hand state flags and last press time (not the frozen pointer) and loads the register defaults.
// ----------------------------------------------------------------------------
module pinch_gesture_qualifier
    import pgq_pkg::*;
#(
    parameter int NUM_HANDS = NUM_HANDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_stall,
    input  sample_t           smp_data,
    output logic              evt_valid,
    input  logic              evt_stall,
    output result_t           evt_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    plan_t plan, head;
    logic  take, push, full, pop, nonempty;

    assign smp_stall = full;
    assign take      = smp_valid && !full;
    assign push      = take && (plan.mask != '0);

    pgq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgq_front #(
        .NUM_HANDS (NUM_HANDS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_data),
        .take  (take),
        .cfg   (cfg),
        .plan  (plan)
    );

    pgq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (plan),
        .full     (full),
        .pop      (pop),
        .dout     (head),
        .nonempty (nonempty)
    );

    pgq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (nonempty),
        .pop        (pop),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data)
    );

endmodule

// File: src/pgq_cfg.sv
// ----------------------------------------------------------------------------
// pgq_cfg
// APB register file: thresholds, windows and capability bits.
// ----------------------------------------------------------------------------
module pgq_cfg
    import pgq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_threshold   <= PRESS_TH_RST;
            cfg_reg.release_threshold <= RELEASE_TH_RST;
            cfg_reg.freeze_threshold  <= FREEZE_TH_RST;
            cfg_reg.double_window     <= DOUBLE_WIN_RST;
            cfg_reg.lockout_window    <= LOCKOUT_RST;
            cfg_reg.aim_supported     <= 1'b0;
            cfg_reg.swipes_supported  <= 1'b0;
            cfg_reg.hands_present     <= HANDS_RST;
        end
        else if (wr)
        begin
            case (idx)
                REG_PRESS_TH:    cfg_reg.press_threshold   <= pwdata[STR_W-1:0];
                REG_RELEASE_TH:  cfg_reg.release_threshold <= pwdata[STR_W-1:0];
                REG_FREEZE_TH:   cfg_reg.freeze_threshold  <= pwdata[STR_W-1:0];
                REG_DOUBLE_WIN:  cfg_reg.double_window     <= pwdata[WIN_W-1:0];
                REG_LOCKOUT_WIN: cfg_reg.lockout_window    <= pwdata[WIN_W-1:0];
                REG_AIM_SUP:     cfg_reg.aim_supported     <= pwdata[0];
                REG_SWIPE_SUP:   cfg_reg.swipes_supported  <= pwdata[0];
                REG_HANDS:       cfg_reg.hands_present     <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_PRESS_TH:    prdata = DATA_W'(cfg_reg.press_threshold);
            REG_RELEASE_TH:  prdata = DATA_W'(cfg_reg.release_threshold);
            REG_FREEZE_TH:   prdata = DATA_W'(cfg_reg.freeze_threshold);
            REG_DOUBLE_WIN:  prdata = DATA_W'(cfg_reg.double_window);
            REG_LOCKOUT_WIN: prdata = DATA_W'(cfg_reg.lockout_window);
            REG_AIM_SUP:     prdata = DATA_W'(cfg_reg.aim_supported);
            REG_SWIPE_SUP:   prdata = DATA_W'(cfg_reg.swipes_supported);
            REG_HANDS:       prdata = DATA_W'(cfg_reg.hands_present);
            default:         prdata = '0;
        endcase
    end

endmodule

// File: src/pgq_front.sv
// ----------------------------------------------------------------------------
// pgq_front
// Sample classifier: lockout, tracking loss, freeze, press/release
// hysteresis, double pinch and swipe edges. Holds the per-hand state and
// builds a plan of up to six result slots for each accepted sample.
// ----------------------------------------------------------------------------
module pgq_front
    import pgq_pkg::*;
#(
    parameter int NUM_HANDS = NUM_HANDS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  sample_t smp,
    input  logic    take,
    input  cfg_t    cfg,
    output plan_t   plan
);

    localparam int HW     = (NUM_HANDS < 2) ? 2 : NUM_HANDS;
    localparam int HIDX_W = $clog2(HW);

    logic [HW-1:0]      pinching_reg, pinching_next;
    logic [HW-1:0]      suppress_reg, suppress_next;
    logic [HW-1:0]      frozen_reg,   frozen_next;
    logic [PT_W-1:0]    frozen_x_reg [HW];
    logic [PT_W-1:0]    frozen_y_reg [HW];
    logic [SWIPE_W-1:0] prev_swipes_reg [HW];
    logic [SWIPE_W-1:0] prev_swipes_next;
    logic [TIME_W-1:0]  last_press_reg, last_press_next;

    logic [HIDX_W-1:0]        hidx;
    logic signed [TIME_W:0]   lock_diff;
    logic signed [TIME_W:0]   dbl_diff;
    logic                     lock_hit;
    logic                     in_window;
    logic                     hand_ok;
    logic                     computed;
    logic                     lost;
    logic                     any_active;
    logic [STR_W-1:0]         pinch;
    logic signed [PT_W-1:0]   x_sel, y_sel, x_out, y_out;
    logic [SWIPE_W-1:0]       rising;
    logic                     fz_we;

    function automatic evt_t mk_evt(kind_t k, logic h, logic [STR_W-1:0] v,
                                    logic signed [PT_W-1:0] px,
                                    logic signed [PT_W-1:0] py);
        evt_t e;
        e.kind  = k;
        e.hand  = h;
        e.value = v;
        e.x     = px;
        e.y     = py;
        return e;
    endfunction

    assign hidx      = HIDX_W'(smp.hand);
    assign lock_diff = $signed({1'b0, smp.now_time}) - $signed({1'b0, smp.controller_time});
    assign dbl_diff  = $signed({1'b0, smp.now_time}) - $signed({1'b0, last_press_reg});
    assign lock_hit  = (cfg.hands_present != 2'b00) && (smp.controller_time != '0)
                       && (lock_diff < $signed({1'b0, 31'b0, cfg.lockout_window}));
    assign in_window = (last_press_reg != '0)
                       && (dbl_diff <= $signed({1'b0, 31'b0, cfg.double_window}));
    assign hand_ok   = (int'(smp.hand) < NUM_HANDS) && cfg.hands_present[smp.hand];
    assign computed  = cfg.aim_supported && smp.aim_status[0];
    assign lost      = !smp.tracked || (computed && smp.aim_status[2]);
    assign any_active = |(pinching_reg | frozen_reg);
    assign pinch     = computed ? smp.pinch_strength : '0;
    assign x_sel     = (computed && smp.aim_status[1]) ? smp.point_x : OFF_PLANE;
    assign y_sel     = (computed && smp.aim_status[1]) ? smp.point_y : OFF_PLANE;
    assign rising    = smp.swipe_flags & ~prev_swipes_reg[hidx];

    always_comb
    begin
        pinching_next    = pinching_reg;
        suppress_next    = suppress_reg;
        frozen_next      = frozen_reg;
        prev_swipes_next = prev_swipes_reg[hidx];
        last_press_next  = last_press_reg;
        fz_we            = 1'b0;
        x_out            = x_sel;
        y_out            = y_sel;
        plan.mask        = '0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            plan.slot[s] = mk_evt(KIND_MOVE, smp.hand, '0, '0, '0);
        end

        if (lock_hit)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (i < NUM_HANDS)
                begin
                    plan.mask[i]     = pinching_reg[i] && !suppress_reg[i];
                    plan.slot[i]     = mk_evt(KIND_UP, 1'(i), '0, '0, '0);
                    plan.mask[2 + i] = any_active;
                    plan.slot[2 + i] = mk_evt(KIND_MOVE, 1'(i), '0, OFF_PLANE, OFF_PLANE);
                end
            end
            pinching_next   = '0;
            suppress_next   = '0;
            frozen_next     = '0;
            last_press_next = '0;
        end
        else if (hand_ok)
        begin
            if (lost)
            begin
                plan.mask[0] = pinching_reg[hidx] && !suppress_reg[hidx];
                plan.slot[0] = mk_evt(KIND_UP, smp.hand, '0, '0, '0);
                plan.mask[1] = 1'b1;
                plan.slot[1] = mk_evt(KIND_MOVE, smp.hand, '0, OFF_PLANE, OFF_PLANE);
                pinching_next[hidx] = 1'b0;
                suppress_next[hidx] = 1'b0;
                frozen_next[hidx]   = 1'b0;
                if (!smp.tracked)
                begin
                    prev_swipes_next = '0;
                end
            end
            else
            begin
                if (pinch >= cfg.freeze_threshold)
                begin
                    frozen_next[hidx] = 1'b1;
                    if (frozen_reg[hidx])
                    begin
                        x_out = $signed(frozen_x_reg[hidx]);
                        y_out = $signed(frozen_y_reg[hidx]);
                    end
                    else
                    begin
                        fz_we = 1'b1;
                    end
                end
                else
                begin
                    frozen_next[hidx] = 1'b0;
                end
                plan.mask[0] = 1'b1;
                plan.slot[0] = mk_evt(KIND_MOVE, smp.hand, '0, x_out, y_out);

                if (!pinching_reg[hidx] && pinch >= cfg.press_threshold)
                begin
                    pinching_next[hidx] = 1'b1;
                    plan.mask[1]        = 1'b1;
                    if (in_window)
                    begin
                        suppress_next[hidx] = 1'b1;
                        last_press_next     = '0;
                        plan.slot[1] = mk_evt(KIND_DOUBLE, smp.hand, pinch, '0, '0);
                    end
                    else
                    begin
                        suppress_next[hidx] = 1'b0;
                        last_press_next     = smp.now_time;
                        plan.slot[1] = mk_evt(KIND_DOWN, smp.hand, pinch, '0, '0);
                    end
                end
                else if (pinching_reg[hidx] && pinch <= cfg.release_threshold)
                begin
                    pinching_next[hidx] = 1'b0;
                    suppress_next[hidx] = 1'b0;
                    plan.mask[1] = !suppress_reg[hidx];
                    plan.slot[1] = mk_evt(KIND_UP, smp.hand, pinch, '0, '0);
                end

                if (cfg.swipes_supported && smp.swipe_flags != prev_swipes_reg[hidx])
                begin
                    for (int i = 0; i < SWIPE_W; i++)
                    begin
                        plan.mask[2 + i] = rising[i];
                        plan.slot[2 + i] = mk_evt(kind_t'(3'(KIND_SWIPE_L) + 3'(i)),
                                                  smp.hand, '0, '0, '0);
                    end
                    prev_swipes_next = smp.swipe_flags;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pinching_reg   <= '0;
            suppress_reg   <= '0;
            frozen_reg     <= '0;
            last_press_reg <= '0;
            for (int i = 0; i < HW; i++)
            begin
                prev_swipes_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            pinching_reg          <= pinching_next;
            suppress_reg          <= suppress_next;
            frozen_reg            <= frozen_next;
            last_press_reg        <= last_press_next;
            prev_swipes_reg[hidx] <= prev_swipes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && fz_we)
        begin
            frozen_x_reg[hidx] <= x_sel;
            frozen_y_reg[hidx] <= y_sel;
        end
    end

endmodule

// File: src/pgq_queue.sv
// ----------------------------------------------------------------------------
// pgq_queue
// Short plan queue between classifier and result serializer.
// ----------------------------------------------------------------------------
module pgq_queue
    import pgq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  plan_t din,
    output logic  full,
    input  logic  pop,
    output plan_t dout,
    output logic  nonempty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    plan_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign dout     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: src/pgq_back.sv
// ----------------------------------------------------------------------------
// pgq_back
// Result serializer: walks the live slots of the head plan, one beat per
// cycle while evt_stall is low, into the output register.
// ----------------------------------------------------------------------------
module pgq_back
    import pgq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  plan_t   head,
    input  logic    head_valid,
    output logic    pop,
    output logic    evt_valid,
    input  logic    evt_stall,
    output result_t evt_data
);

    logic [SLOT_COUNT-1:0] done_reg;
    logic [SLOT_COUNT-1:0] rem, pick;
    logic                  is_last;
    logic                  load;
    logic                  out_valid_reg;
    result_t               out_data_reg;
    evt_t                  sel;

    assign rem     = head.mask & ~done_reg;
    assign pick    = rem & (~rem + 1'b1);
    assign is_last = ((rem & ~pick) == '0);
    assign load    = head_valid && (!out_valid_reg || !evt_stall);
    assign pop     = load && is_last;

    always_comb
    begin
        sel = '0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (pick[s])
            begin
                sel = head.slot[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                done_reg      <= is_last ? '0 : (done_reg | pick);
                out_valid_reg <= 1'b1;
            end
            else if (!evt_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.event_kind  <= sel.kind;
            out_data_reg.event_hand  <= sel.hand;
            out_data_reg.event_value <= sel.value;
            out_data_reg.pointer_x   <= sel.x;
            out_data_reg.pointer_y   <= sel.y;
            out_data_reg.last        <= is_last;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt_data  = out_data_reg;

endmodule

// File: src/pgq_checker.sv
// ----------------------------------------------------------------------------
// pgq_checker
// Port-level checks of the pinch gesture qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module pgq_checker
    import pgq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              smp_stall,
    input logic              evt_valid,
    input logic              evt_stall,
    input result_t           evt_data
);

    // held result beat
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt_data))
        else $error("result beat changed while stalled");

    // input backpressure only with results pending
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        smp_stall |-> evt_valid)
        else $error("input stalled with no result pending");

    // results of one sample leave back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && !evt_data.last |=> evt_valid)
        else $error("gap inside a result burst");

    a_pointer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_data.event_kind != KIND_MOVE
        |-> evt_data.pointer_x == '0 && evt_data.pointer_y == '0)
        else $error("pointer set on a non-move result");

endmodule

bind pinch_gesture_qualifier pgq_checker u_pgq_checker (.*);
